### design/sgst_pkg.sv
// Shared widths, register indexes and the scale unit result type.
`timescale 1ns / 1ps
`default_nettype none
package sgst_pkg;

  localparam int DATA_W    = 32;
  localparam int THR_W     = 31;
  localparam int SUM_W     = 64;
  localparam int MULT_W    = 33;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_L1_THRESHOLD    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GROUP_THRESHOLD = 1'b1;

  // Result of the root and divide unit
  typedef struct packed {
    logic              done;
    logic [MULT_W-1:0] mult;
  } sgst_scale_t;

endpackage
`default_nettype wire

### design/sgst_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module sgst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic                                       re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### design/sgst_root_div.sv
// Iterative integer square root followed by a restoring divide for the scale factor.
`timescale 1ns / 1ps
`default_nettype none
module sgst_root_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [sgst_pkg::SUM_W-1:0]    sum_i,
  input  wire logic [sgst_pkg::THR_W-1:0]    t2_i,
  output sgst_pkg::sgst_scale_t              scale_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SQRT = 2'd1;
  localparam logic [1:0] ST_DIVI = 2'd2;
  localparam logic [1:0] ST_DIV  = 2'd3;

  localparam int HALF_W = sgst_pkg::SUM_W / 2;

  logic [1:0]                    state_r, state_nxt;
  logic [4:0]                    step_r, step_nxt;
  logic [sgst_pkg::SUM_W-1:0]    v_r, v_nxt;
  logic [sgst_pkg::SUM_W-1:0]    root_r, root_nxt;
  logic [sgst_pkg::SUM_W-1:0]    bit_r, bit_nxt;
  logic [HALF_W-1:0]             n_r, n_nxt;
  logic [HALF_W-1:0]             rem_r, rem_nxt;
  logic [HALF_W-1:0]             q_r, q_nxt;
  logic                          qint_r, qint_nxt;
  logic                          done_r, done_nxt;

  logic [sgst_pkg::SUM_W-1:0]    trial;
  logic [HALF_W-1:0]             t2_ext;
  logic [HALF_W-1:0]             n_nz;
  logic [HALF_W-1:0]             n_cl;
  logic [HALF_W:0]               rem_sh;
  logic                          rem_ge;

  assign t2_ext = {1'b0, t2_i};
  assign trial  = root_r + bit_r;
  assign n_nz   = (root_r[HALF_W-1:0] == '0) ? HALF_W'(1) : root_r[HALF_W-1:0];
  assign n_cl   = (n_nz < t2_ext) ? t2_ext : n_nz;
  assign rem_sh = {rem_r, 1'b0};
  assign rem_ge = (rem_sh >= {1'b0, n_r});

  // Sequence the root and divide steps
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    v_nxt     = v_r;
    root_nxt  = root_r;
    bit_nxt   = bit_r;
    n_nxt     = n_r;
    rem_nxt   = rem_r;
    q_nxt     = q_r;
    qint_nxt  = qint_r;
    done_nxt  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          v_nxt     = sum_i;
          root_nxt  = '0;
          bit_nxt   = {2'b01, {(sgst_pkg::SUM_W-2){1'b0}}};
          step_nxt  = '0;
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        // one result bit per step
        if (v_r >= trial) begin
          v_nxt    = v_r - trial;
          root_nxt = (root_r >> 1) + bit_r;
        end else begin
          root_nxt = root_r >> 1;
        end
        bit_nxt  = bit_r >> 2;
        step_nxt = step_r + 5'd1;
        if (step_r == 5'd31) begin
          state_nxt = ST_DIVI;
        end
      end
      ST_DIVI: begin
        // clamp the norm, take the integer part of (n - t2) / n
        n_nxt     = n_cl;
        qint_nxt  = (t2_i == '0);
        rem_nxt   = (t2_i == '0) ? '0 : (n_cl - t2_ext);
        step_nxt  = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        // one fraction bit per step
        rem_nxt  = rem_ge ? HALF_W'(rem_sh - {1'b0, n_r}) : rem_sh[HALF_W-1:0];
        q_nxt    = {q_r[HALF_W-2:0], rem_ge};
        step_nxt = step_r + 5'd1;
        if (step_r == 5'd31) begin
          done_nxt  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    v_r    <= v_nxt;
    root_r <= root_nxt;
    bit_r  <= bit_nxt;
    n_r    <= n_nxt;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    qint_r <= qint_nxt;
  end

  assign scale_o.done = done_r;
  assign scale_o.mult = {qint_r, q_r};

endmodule
`default_nettype wire

### design/sparse_group_soft_threshold_top.sv
// Sparse-group soft threshold: buffer a group, form its norm, emit scaled words.
//
// Input words (in_element_value, in_last_element) arrive on a valid/ready
// channel. Each word is soft-thresholded by l1_threshold and written to a
// MAX_GROUP_LEN-entry buffer RAM while its square joins a saturating 64-bit sum;
// words are taken one per cycle until the word flagged last. Words beyond
// MAX_GROUP_LEN are dropped and flag the group as overflowed.
// After the last word, states DRAIN1 and DRAIN2 let the sum settle and DECIDE
// tests it against group_threshold squared. A group that is kept then passes
// through the root/divide unit (32 root steps, 1 clamp step, 32 divide steps,
// 1 hand over). Results leave through a three-stage read/multiply/round
// pipeline, one word per cycle while out_ready is high.
// in_ready is low from the last word until the group's last result is taken.
// While a result waits on out_ready, the emission pipeline and read port hold.
// Reset (rst_n, synchronous) clears the thresholds, count, sum and flags; the
// buffer needs no clearing, as only entries written in the current group are read.
// Configuration (cfg_wr_en, cfg_index, cfg_wdata) is for the user to write only
// while idle; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
module sparse_group_soft_threshold_top #(
  parameter int MAX_GROUP_LEN = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // configuration port
  input  wire logic                              cfg_wr_en,
  input  wire logic [sgst_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [sgst_pkg::THR_W-1:0]        cfg_wdata,
  // input channel
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic signed [sgst_pkg::DATA_W-1:0] in_element_value,
  input  wire logic                              in_last_element,
  // result channel
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [sgst_pkg::DATA_W-1:0]     out_shrunk_value,
  output logic                                   out_last_result,
  output logic                                   out_group_zeroed,
  output logic                                   out_overflow_flag
);

  localparam int AW = (MAX_GROUP_LEN > 1) ? $clog2(MAX_GROUP_LEN) : 1;
  localparam int CW = $clog2(MAX_GROUP_LEN + 1);
  localparam int DW = sgst_pkg::DATA_W;
  localparam int SW = sgst_pkg::SUM_W;
  localparam int TW = sgst_pkg::THR_W;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_GROUP_LEN);

  localparam logic [2:0] ST_LOAD   = 3'd0;
  localparam logic [2:0] ST_DRAIN1 = 3'd1;
  localparam logic [2:0] ST_DRAIN2 = 3'd2;
  localparam logic [2:0] ST_DECIDE = 3'd3;
  localparam logic [2:0] ST_ROOT   = 3'd4;
  localparam logic [2:0] ST_EMIT   = 3'd5;

  // ---------------------------------------------------------------- registers
  logic [2:0]                  state_r, state_nxt;
  logic [TW-1:0]               l1_thr_r, grp_thr_r;
  logic [2*TW-1:0]             t2sq_r;
  logic [CW-1:0]               count_r, count_nxt;
  logic [SW-1:0]               sum_r, sum_nxt;
  logic                        sat_r, sat_nxt;
  logic                        ovf_r, ovf_nxt;
  logic                        zeroed_r, zeroed_nxt;
  logic [sgst_pkg::MULT_W-1:0] mult_r, mult_nxt;
  logic [CW-1:0]               rd_idx_r, rd_idx_nxt;

  // load pipeline
  logic [DW-1:0]               s_r;
  logic                        s_vld_r;
  logic [SW-1:0]               sq_r;
  logic                        sq_vld_r;

  // emission pipeline
  logic                        p1_vld_r, p1_last_r;
  logic                        p2_vld_r, p2_last_r, p2_neg_r;
  logic [SW-1:0]               prod_r;
  logic                        out_valid_r, out_last_r;
  logic [DW-1:0]               out_value_r;

  // ---------------------------------------------------------------- wires
  logic                        in_acc;
  logic                        out_acc;
  logic                        buffered;
  logic signed [DW:0]          x_ext, t_ext;
  logic signed [DW:0]          s_full;
  logic [DW-1:0]               s_val;
  logic [DW-1:0]               s_mag;
  logic [SW-1:0]               sq_full;
  logic [SW:0]                 sum_add;
  logic                        grp_zero;
  logic                        issue;
  logic                        adv;
  logic [DW-1:0]               rd_data;
  logic [DW-1:0]               rd_mag;
  logic [SW-1:0]               prod_full;
  logic [SW-1:0]               prod_rnd;
  logic [DW-1:0]               p_mag;
  logic                        root_start;
  sgst_pkg::sgst_scale_t       scale;

  assign in_ready = (state_r == ST_LOAD);
  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid_r && out_ready;
  assign buffered = (count_r < MAX_CNT);

  // Soft threshold the incoming word
  assign x_ext = {in_element_value[DW-1], in_element_value};
  assign t_ext = {2'b00, l1_thr_r};
  always_comb begin
    if (x_ext > t_ext) begin
      s_full = x_ext - t_ext;
    end else if (x_ext < -t_ext) begin
      s_full = x_ext + t_ext;
    end else begin
      s_full = '0;
    end
  end
  assign s_val = s_full[DW-1:0];

  // Square the buffered word, then add with saturation
  assign s_mag   = s_r[DW-1] ? (~s_r + DW'(1)) : s_r;
  assign sq_full = {{DW{1'b0}}, s_mag} * {{DW{1'b0}}, s_mag};
  assign sum_add = {1'b0, sum_r} + {1'b0, sq_r};

  assign grp_zero = sat_r || (sum_r <= {{(SW-2*TW){1'b0}}, t2sq_r});

  // Emission pipeline control
  assign adv   = !out_valid_r || out_ready;
  assign issue = (state_r == ST_EMIT) && (rd_idx_r < count_r);

  assign rd_mag    = rd_data[DW-1] ? (~rd_data + DW'(1)) : rd_data;
  assign prod_full = mult_r[sgst_pkg::MULT_W-1] ? {rd_mag, {DW{1'b0}}}
                   : ({{DW{1'b0}}, rd_mag} * {{DW{1'b0}}, mult_r[DW-1:0]});
  assign prod_rnd  = prod_r + {{(SW-DW){1'b0}}, 1'b1, {(DW-1){1'b0}}};
  assign p_mag     = prod_rnd[SW-1:SW-DW];

  assign root_start = (state_r == ST_DECIDE) && !grp_zero;

  // ---------------------------------------------------------------- buffer RAM
  sgst_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_GROUP_LEN)
  ) u_buf (
    .clk   (clk),
    .we    (in_acc && buffered),
    .waddr (count_r[AW-1:0]),
    .wdata (s_val),
    .re    (issue && adv),
    .raddr (rd_idx_r[AW-1:0]),
    .rdata (rd_data)
  );

  // ---------------------------------------------------------------- root and divide
  sgst_root_div u_root_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (root_start),
    .sum_i   (sum_r),
    .t2_i    (grp_thr_r),
    .scale_o (scale)
  );

  // ---------------------------------------------------------------- group control
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    sum_nxt    = sum_r;
    sat_nxt    = sat_r;
    ovf_nxt    = ovf_r;
    zeroed_nxt = zeroed_r;
    mult_nxt   = mult_r;
    rd_idx_nxt = rd_idx_r;

    // count and drop words
    if (in_acc) begin
      if (buffered) begin
        count_nxt = count_r + CW'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end

    // accumulate squares
    if (sq_vld_r) begin
      if (sat_r || sum_add[SW]) begin
        sum_nxt = '1;
        sat_nxt = 1'b1;
      end else begin
        sum_nxt = sum_add[SW-1:0];
      end
    end

    if (issue && adv) begin
      rd_idx_nxt = rd_idx_r + CW'(1);
    end

    case (state_r)
      ST_LOAD: begin
        if (in_acc && in_last_element) begin
          state_nxt = ST_DRAIN1;
        end
      end
      ST_DRAIN1: begin
        state_nxt = ST_DRAIN2;
      end
      ST_DRAIN2: begin
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        zeroed_nxt = grp_zero;
        rd_idx_nxt = '0;
        mult_nxt   = '0;
        state_nxt  = grp_zero ? ST_EMIT : ST_ROOT;
      end
      ST_ROOT: begin
        if (scale.done) begin
          mult_nxt  = scale.mult;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // drop the group state once its last word is taken
        if (out_acc && out_last_r) begin
          count_nxt = '0;
          sum_nxt   = '0;
          sat_nxt   = 1'b0;
          ovf_nxt   = 1'b0;
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      l1_thr_r    <= '0;
      grp_thr_r   <= '0;
      count_r     <= '0;
      sum_r       <= '0;
      sat_r       <= 1'b0;
      ovf_r       <= 1'b0;
      zeroed_r    <= 1'b0;
      rd_idx_r    <= '0;
      s_vld_r     <= 1'b0;
      sq_vld_r    <= 1'b0;
      p1_vld_r    <= 1'b0;
      p2_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      sum_r    <= sum_nxt;
      sat_r    <= sat_nxt;
      ovf_r    <= ovf_nxt;
      zeroed_r <= zeroed_nxt;
      rd_idx_r <= rd_idx_nxt;
      s_vld_r  <= in_acc && buffered;
      sq_vld_r <= s_vld_r;
      if (cfg_wr_en) begin
        case (cfg_index)
          sgst_pkg::REG_L1_THRESHOLD:    l1_thr_r  <= cfg_wdata;
          sgst_pkg::REG_GROUP_THRESHOLD: grp_thr_r <= cfg_wdata;
          default: ;
        endcase
      end
      // advance the emission pipeline, hold it while the receiver stalls
      if (adv) begin
        p1_vld_r    <= issue;
        p2_vld_r    <= p1_vld_r;
        out_valid_r <= p2_vld_r;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    mult_r <= mult_nxt;
    t2sq_r <= {{TW{1'b0}}, grp_thr_r} * {{TW{1'b0}}, grp_thr_r};
    s_r    <= s_val;
    sq_r   <= sq_full;
    if (adv) begin
      p1_last_r   <= ((rd_idx_r + CW'(1)) == count_r);
      prod_r      <= prod_full;
      p2_neg_r    <= rd_data[DW-1];
      p2_last_r   <= p1_last_r;
      out_value_r <= p2_neg_r ? (~p_mag + DW'(1)) : p_mag;
      out_last_r  <= p2_last_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_shrunk_value  = out_value_r;
  assign out_last_result   = out_last_r;
  assign out_group_zeroed  = zeroed_r;
  assign out_overflow_flag = ovf_r;

endmodule
`default_nettype wire

### test/sgst_group_checker.sv
// Group checker: predicts the shrunk words of each group and compares them on the result channel.
`timescale 1ns / 1ps
module sgst_group_checker #(
  parameter int MAX_GROUP_LEN = 64
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_wr_en,
  input  wire logic [sgst_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [sgst_pkg::THR_W-1:0]         cfg_wdata,
  input  wire logic                               in_valid,
  input  wire logic                               in_ready,
  input  wire logic signed [sgst_pkg::DATA_W-1:0] in_element_value,
  input  wire logic                               in_last_element,
  input  wire logic                               out_valid,
  input  wire logic                               out_ready,
  input  wire logic signed [sgst_pkg::DATA_W-1:0] out_shrunk_value,
  input  wire logic                               out_last_result,
  input  wire logic                               out_group_zeroed,
  input  wire logic                               out_overflow_flag,
  output int                                      fail_count,
  output int                                      pending_results,
  output int                                      results_checked
);

  typedef struct {
    logic signed [sgst_pkg::DATA_W-1:0] value;
    logic                               last;
    logic                               zeroed;
    logic                               overflow;
  } shrunk_word_t;

  shrunk_word_t                       pending_shrunk_words[$];
  logic [sgst_pkg::THR_W-1:0]         l1_thr;
  logic [sgst_pkg::THR_W-1:0]         group_thr;
  logic signed [sgst_pkg::DATA_W-1:0] shrunk_store [MAX_GROUP_LEN];
  int                                 stored_count;
  logic [sgst_pkg::SUM_W-1:0]         square_sum;
  logic                               sum_saturated;
  logic                               group_overflowed;
  int                                 mismatches;
  int                                 checked;

  // Soft-threshold one word into the group; on the last word, queue the group's results
  task automatic shrink_word(input logic signed [sgst_pkg::DATA_W-1:0] value,
                             input logic last);
    longint                     shrunk;
    longint                     scaled;
    logic [sgst_pkg::SUM_W-1:0] mag;
    logic [sgst_pkg::SUM_W-1:0] square;
    logic [sgst_pkg::SUM_W-1:0] rem;
    logic [sgst_pkg::SUM_W-1:0] root;
    logic [sgst_pkg::SUM_W-1:0] bitv;
    logic [sgst_pkg::SUM_W-1:0] norm;
    logic [sgst_pkg::SUM_W-1:0] mult;
    logic [sgst_pkg::SUM_W-1:0] thr2;
    logic [sgst_pkg::SUM_W-1:0] prod;
    logic                       zero_group;
    shrunk_word_t               w;

    if (longint'(value) > longint'(l1_thr)) begin
      shrunk = longint'(value) - longint'(l1_thr);
    end else if (longint'(value) < -longint'(l1_thr)) begin
      shrunk = longint'(value) + longint'(l1_thr);
    end else begin
      shrunk = 0;
    end

    // Buffer and sum while there is room; drop the rest and mark the group
    if (stored_count < MAX_GROUP_LEN) begin
      mag = (shrunk < 0) ? -shrunk : shrunk;
      square = mag * mag;
      shrunk_store[stored_count] = shrunk[sgst_pkg::DATA_W-1:0];
      stored_count++;
      if (sum_saturated || square_sum > ({sgst_pkg::SUM_W{1'b1}} - square)) begin
        square_sum = {sgst_pkg::SUM_W{1'b1}};
        sum_saturated = 1'b1;
      end else begin
        square_sum += square;
      end
    end else begin
      group_overflowed = 1'b1;
    end

    if (!last) return;

    thr2 = {{(sgst_pkg::SUM_W-sgst_pkg::THR_W){1'b0}}, group_thr};
    zero_group = sum_saturated || (square_sum <= thr2 * thr2);
    mult = '0;
    if (!zero_group) begin
      // Integer square root, two bits of the radicand per step
      rem = square_sum;
      root = '0;
      bitv = 64'h4000_0000_0000_0000;
      while (bitv > rem) bitv >>= 2;
      while (bitv != 0) begin
        if (rem >= root + bitv) begin
          rem -= root + bitv;
          root = (root >> 1) + bitv;
        end else begin
          root >>= 1;
        end
        bitv >>= 2;
      end
      norm = (root == 0) ? 64'd1 : root;
      if (norm < thr2) norm = thr2;
      mult = ((norm - thr2) << 32) / norm;
    end

    // Scale each buffered word, rounding the magnitude half away from zero
    for (int k = 0; k < stored_count; k++) begin
      scaled = 0;
      if (!zero_group) begin
        mag = (shrunk_store[k] < 0) ? -longint'(shrunk_store[k])
                                    : longint'(shrunk_store[k]);
        prod = (mag * mult + 64'h8000_0000) >> 32;
        scaled = (shrunk_store[k] < 0) ? -longint'(prod) : longint'(prod);
      end
      w.value = scaled[sgst_pkg::DATA_W-1:0];
      w.last = (k == stored_count - 1);
      w.zeroed = zero_group;
      w.overflow = group_overflowed;
      pending_shrunk_words = {pending_shrunk_words, w};
    end

    stored_count = 0;
    square_sum = '0;
    sum_saturated = 1'b0;
    group_overflowed = 1'b0;
  endtask

  always @(posedge clk) begin
    shrunk_word_t want;
    if (!rst_n) begin
      l1_thr = '0;
      group_thr = '0;
      stored_count = 0;
      square_sum = '0;
      sum_saturated = 1'b0;
      group_overflowed = 1'b0;
      pending_shrunk_words.delete();
    end else begin
      // Track register writes
      if (cfg_wr_en) begin
        case (cfg_index)
          sgst_pkg::REG_L1_THRESHOLD:    l1_thr = cfg_wdata;
          sgst_pkg::REG_GROUP_THRESHOLD: group_thr = cfg_wdata;
          default: ;
        endcase
      end

      // Compare each accepted result word with the oldest prediction
      if (out_valid && out_ready) begin
        if (pending_shrunk_words.size() == 0) begin
          $error("result word with no prediction waiting: shrunk_value %0d", out_shrunk_value);
          mismatches++;
        end else begin
          want = pending_shrunk_words.pop_front();
          if (out_shrunk_value !== want.value) begin
            $error("shrunk_value: expected %0d, actual %0d", want.value, out_shrunk_value);
            mismatches++;
          end
          if (out_last_result !== want.last) begin
            $error("last_result: expected %0b, actual %0b", want.last, out_last_result);
            mismatches++;
          end
          if (out_group_zeroed !== want.zeroed) begin
            $error("group_zeroed: expected %0b, actual %0b", want.zeroed, out_group_zeroed);
            mismatches++;
          end
          if (out_overflow_flag !== want.overflow) begin
            $error("overflow_flag: expected %0b, actual %0b", want.overflow,
                   out_overflow_flag);
            mismatches++;
          end
          checked++;
        end
      end

      if (in_valid && in_ready) begin
        shrink_word(in_element_value, in_last_element);
      end
    end

    fail_count      <= mismatches;
    results_checked <= checked;
    pending_results <= pending_shrunk_words.size();
  end

endmodule

### test/sparse_group_soft_threshold_top_test.sv
// Testbench top: drives groups and threshold settings into the block and gives the verdict.
`timescale 1ns / 1ps
module sparse_group_soft_threshold_top_test;

  localparam int                         GROUP_LEN       = 64;
  localparam int                         WORDS_TARGET    = 320;
  localparam int                         IDLE_LIMIT      = 4000;
  localparam int                         SETTLE_CYCLES   = 80;
  localparam int                         HOLD_OFF_CYCLES = 400;
  localparam int                         TW              = sgst_pkg::THR_W;
  localparam logic [sgst_pkg::THR_W-1:0] THR_MAX         = '1;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               cfg_wr_en = 1'b0;
  logic [sgst_pkg::CFG_IDX_W-1:0]     cfg_index = sgst_pkg::REG_L1_THRESHOLD;
  logic [sgst_pkg::THR_W-1:0]         cfg_wdata = '0;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic signed [sgst_pkg::DATA_W-1:0] in_element_value = '0;
  logic                               in_last_element = 1'b0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic signed [sgst_pkg::DATA_W-1:0] out_shrunk_value;
  logic                               out_last_result;
  logic                               out_group_zeroed;
  logic                               out_overflow_flag;

  int fail_count;
  int pending_results;
  int results_checked;
  int send_gap_max = 0;
  int sink_stall_max = 0;
  int sink_hold_req = 0;
  int words_sent = 0;
  int groups_sent = 0;
  int long_groups = 0;
  int settings_used = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sparse_group_soft_threshold_top #(
    .MAX_GROUP_LEN(GROUP_LEN)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_element_value  (in_element_value),
    .in_last_element   (in_last_element),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_shrunk_value  (out_shrunk_value),
    .out_last_result   (out_last_result),
    .out_group_zeroed  (out_group_zeroed),
    .out_overflow_flag (out_overflow_flag)
  );

  sgst_group_checker #(
    .MAX_GROUP_LEN(GROUP_LEN)
  ) u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_element_value  (in_element_value),
    .in_last_element   (in_last_element),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_shrunk_value  (out_shrunk_value),
    .out_last_result   (out_last_result),
    .out_group_zeroed  (out_group_zeroed),
    .out_overflow_flag (out_overflow_flag),
    .fail_count        (fail_count),
    .pending_results   (pending_results),
    .results_checked   (results_checked)
  );

  function automatic int draw_wait(input int wait_limit);
    return (wait_limit == 0) ? 0 : $urandom_range(0, wait_limit);
  endfunction

  function automatic int draw_idle_limit();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 3;
      default: return 18;
    endcase
  endfunction

  // Spread thresholds over zero, full scale and several magnitudes
  function automatic logic [sgst_pkg::THR_W-1:0] draw_threshold();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return THR_MAX;
      2:       return TW'($urandom_range(0, 32'h0001_0000));
      3:       return TW'($urandom_range(0, 32'h0100_0000));
      default: return TW'($urandom() >> 1);
    endcase
  endfunction

  // Offer one word after a random gap and hold it until taken
  task automatic send_word(input logic signed [sgst_pkg::DATA_W-1:0] value, input logic last);
    int gap;
    gap = draw_wait(send_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_element_value <= value;
    in_last_element <= last;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  // Stop offering, wait for every predicted result, then let the block settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both thresholds while the block is idle
  task automatic set_thresholds(input logic [sgst_pkg::THR_W-1:0] l1,
                                input logic [sgst_pkg::THR_W-1:0] grp);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_index <= sgst_pkg::REG_L1_THRESHOLD;
    cfg_wdata <= l1;
    @(posedge clk);
    cfg_index <= sgst_pkg::REG_GROUP_THRESHOLD;
    cfg_wdata <= grp;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  // Send one group of random words, the final one flagged last
  task automatic send_group(input int len);
    logic signed [sgst_pkg::DATA_W-1:0] value;
    int                                 mix;
    for (int k = 0; k < len; k++) begin
      mix = $urandom_range(0, 9);
      case (mix)
        0, 1, 2: value = $urandom_range(0, 32'h0004_0000);
        3, 4, 5: value = $urandom_range(0, 32'h0100_0000);
        6, 7, 8: value = $urandom();
        default: begin
          case ($urandom_range(0, 3))
            0:       value = 32'h7FFF_FFFF;
            1:       value = 32'h8000_0000;
            2:       value = '0;
            default: value = -1;
          endcase
        end
      endcase
      if (mix < 6 && $urandom_range(0, 1)) value = -value;
      send_word(value, k == len - 1);
    end
    groups_sent++;
    if (len > GROUP_LEN) long_groups++;
  endtask

  // Result side: random stall per word, plus one long hold-off on request
  initial begin : result_sink
    int stall;
    forever begin
      if (sink_hold_req != 0) begin
        sink_hold_req = 0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      stall = draw_wait(sink_stall_max);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Abort when neither channel moves a word for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
    $display("sparse_group_soft_threshold_top: mismatch");
    $finish;
  end

  initial begin : stimulus
    int len;
    int pick;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Field extremes, then a group whose square sum saturates, then an all-zero group
    set_thresholds('0, 31'h0001_0000);
    send_word(32'h7FFF_FFFF, 1'b0);
    send_word(32'h8000_0000, 1'b0);
    send_word('0, 1'b0);
    send_word(32'h0000_0001, 1'b0);
    send_word(-1, 1'b1);
    for (int k = 0; k < 4; k++) send_word(32'h8000_0000, k == 3);
    send_word('0, 1'b1);

    // Zero thresholds: zero group is zeroed, a lone word passes unscaled
    send_gap_max = 18;
    sink_stall_max = 18;
    set_thresholds('0, '0);
    send_word('0, 1'b0);
    send_word('0, 1'b1);
    send_word(32'h0001_0000, 1'b1);

    // Full-scale thresholds shrink everything away
    set_thresholds(THR_MAX, THR_MAX);
    send_word(32'h8000_0000, 1'b0);
    send_word(32'h7FFF_FFFF, 1'b1);

    // Words on and either side of the elementwise threshold
    set_thresholds(31'h0000_8000, 31'h0000_4000);
    send_word(32'h0001_8000, 1'b0);
    send_word(32'hFFFE_8000, 1'b0);
    send_word(32'h0000_4000, 1'b1);
    send_word(32'h0000_8000, 1'b0);
    send_word(32'hFFFF_8000, 1'b1);

    // Random phases: new thresholds and idling per phase, mostly short groups
    for (int phase = 0; words_sent < WORDS_TARGET; phase++) begin
      set_thresholds(draw_threshold(), draw_threshold());
      send_gap_max = draw_idle_limit();
      sink_stall_max = draw_idle_limit();
      case (phase)
        0: send_group(GROUP_LEN + 1);
        1: begin
          // Hold the result side off while words keep coming
          send_gap_max = 0;
          sink_hold_req = 1;
        end
        2: send_group(GROUP_LEN);
        default: ;
      endcase
      repeat ($urandom_range(3, 6)) begin
        pick = $urandom_range(0, 99);
        if (pick < 85) len = $urandom_range(1, 6);
        else if (pick < 98) len = $urandom_range(7, 24);
        else len = $urandom_range(GROUP_LEN, GROUP_LEN + 3);
        send_group(len);
      end
    end

    wait_drained();
    $display("run covered %0d words in %0d groups (%0d longer than the buffer) over %0d settings",
             words_sent, groups_sent, long_groups, settings_used);
    $display("%0d result words compared, %0d field mismatches", results_checked, fail_count);
    if (fail_count == 0) begin
      $display("sparse_group_soft_threshold_top: match");
    end else begin
      $display("sparse_group_soft_threshold_top: mismatch");
    end
    $finish;
  end

endmodule
